// ===== hdl/mhec_pkg.sv =====
`timescale 1ns / 1ps

package mhec_pkg;

    // Width of the ratio samples and of every configuration register.
    localparam int unsigned DATA_W = 16;

    // Configuration port.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT      = 2'd3;

    // Register values after reset.
    localparam logic [DATA_W-1:0] RST_CLOSE_THRESHOLD = 16'd3277;
    localparam logic [DATA_W-1:0] RST_OPEN_THRESHOLD  = 16'd4096;
    localparam logic [DATA_W-1:0] RST_CLOSED_LIMIT    = 16'd15;
    localparam logic [DATA_W-1:0] RST_OPEN_LIMIT      = 16'd10;

    // Saturation value of the debounce counters.
    localparam logic [DATA_W-1:0] COUNT_MAX = 16'hFFFF;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_OUT
    } t_state;

    // Configuration register set.
    typedef struct packed {
        logic [DATA_W-1:0] close_threshold;
        logic [DATA_W-1:0] open_threshold;
        logic [DATA_W-1:0] closed_limit;
        logic [DATA_W-1:0] open_limit;
    } t_cfg;

    // Operation applied to the sorted cell chain.
    typedef struct packed {
        logic del;   // remove the oldest sample and close the gap
        logic ins;   // insert the new sample at its sorted place
        logic full;  // the window holds all of its samples
    } t_chain_ctrl;

endpackage

// ===== hdl/mhec_if.sv =====
`timescale 1ns / 1ps

// Request channel carrying one pair of eye ratios.
interface mhec_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_ratio;
    logic [15:0] right_ratio;

    modport source (output valid, output left_ratio, output right_ratio, input ready);
    modport sink   (input valid, input left_ratio, input right_ratio, output ready);
endinterface

// Result channel carrying the filtered ratio and the drowsy flag.
interface mhec_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] filtered_ratio;
    logic        drowsy;

    modport source (output valid, output filtered_ratio, output drowsy, input ready);
    modport sink   (input valid, input filtered_ratio, input drowsy, output ready);
endinterface

// ===== hdl/mhec_cell.sv =====
`timescale 1ns / 1ps

module mhec_cell #(
    parameter int unsigned AW       = 3,
    parameter int unsigned KILL_AGE = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mhec_pkg::t_chain_ctrl        i_ctrl,
    input  logic [mhec_pkg::DATA_W-1:0]  i_new_value,
    // Left neighbor (smaller values).
    input  logic                         i_left_gt,
    input  logic                         i_left_valid,
    input  logic [mhec_pkg::DATA_W-1:0]  i_left_value,
    input  logic [AW-1:0]                i_left_age,
    // Right neighbor (larger values).
    input  logic                         i_right_valid,
    input  logic [mhec_pkg::DATA_W-1:0]  i_right_value,
    input  logic [AW-1:0]                i_right_age,
    input  logic                         i_gap,
    output logic                         o_gap,
    output logic                         o_gt,
    output logic                         o_valid,
    output logic [mhec_pkg::DATA_W-1:0]  o_value,
    output logic [AW-1:0]                o_age
);
    import mhec_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_value;
    logic [AW-1:0]     r_age;
    logic              n_valid;
    logic [DATA_W-1:0] n_value;
    logic [AW-1:0]     n_age;
    logic              kill;

    // This cell holds the oldest sample of a full window.
    assign kill  = i_ctrl.full && r_valid && (r_age == AW'(KILL_AGE));
    // A gap at or below this cell pulls the right neighbor down.
    assign o_gap = i_gap || kill;
    // An empty cell counts as larger than any sample.
    assign o_gt  = !r_valid || (r_value > i_new_value);

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_age   = r_age;

    // Next cell contents for a delete or an insert step.
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_age   = r_age;
        if (i_ctrl.del) begin
            if (o_gap) begin
                n_valid = i_right_valid;
                n_value = i_right_value;
                n_age   = i_right_age;
            end
        end else if (i_ctrl.ins) begin
            if (o_gt && !i_left_gt) begin
                n_valid = 1'b1;
                n_value = i_new_value;
                n_age   = '0;
            end else if (i_left_gt) begin
                n_valid = i_left_valid;
                n_value = i_left_value;
                n_age   = i_left_age + AW'(1);
            end else begin
                n_age   = r_age + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

endmodule

// ===== hdl/mhec_chain.sv =====
`timescale 1ns / 1ps

module mhec_chain #(
    parameter int unsigned WINDOW = 5,
    parameter int unsigned AW     = 3
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  mhec_pkg::t_chain_ctrl                    i_ctrl,
    input  logic [mhec_pkg::DATA_W-1:0]              i_new_value,
    output logic [WINDOW-1:0][mhec_pkg::DATA_W-1:0]  o_values
);
    import mhec_pkg::*;

    logic [WINDOW-1:0]             valid;
    logic [WINDOW-1:0][DATA_W-1:0] value;
    logic [WINDOW-1:0][AW-1:0]     age;
    logic [WINDOW-1:0]             gt;
    logic [WINDOW-1:0]             gap;

    assign o_values = value;

    // Row of cells kept in ascending order; each cell talks to its two neighbors.
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        logic              left_gt;
        logic              left_valid;
        logic [DATA_W-1:0] left_value;
        logic [AW-1:0]     left_age;
        logic              right_valid;
        logic [DATA_W-1:0] right_value;
        logic [AW-1:0]     right_age;
        logic              gap_in;

        if (g == 0) begin : g_first
            assign left_gt    = 1'b0;
            assign left_valid = 1'b0;
            assign left_value = '0;
            assign left_age   = '0;
            assign gap_in     = 1'b0;
        end else begin : g_inner_left
            assign left_gt    = gt[g-1];
            assign left_valid = valid[g-1];
            assign left_value = value[g-1];
            assign left_age   = age[g-1];
            assign gap_in     = gap[g-1];
        end

        if (g == WINDOW - 1) begin : g_last
            assign right_valid = 1'b0;
            assign right_value = '0;
            assign right_age   = '0;
        end else begin : g_inner_right
            assign right_valid = valid[g+1];
            assign right_value = value[g+1];
            assign right_age   = age[g+1];
        end

        mhec_cell #(
            .AW       (AW),
            .KILL_AGE (WINDOW - 1)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (i_ctrl),
            .i_new_value   (i_new_value),
            .i_left_gt     (left_gt),
            .i_left_valid  (left_valid),
            .i_left_value  (left_value),
            .i_left_age    (left_age),
            .i_right_valid (right_valid),
            .i_right_value (right_value),
            .i_right_age   (right_age),
            .i_gap         (gap_in),
            .o_gap         (gap[g]),
            .o_gt          (gt[g]),
            .o_valid       (valid[g]),
            .o_value       (value[g]),
            .o_age         (age[g])
        );
    end

endmodule

// ===== hdl/mhec_debounce.sv =====
`timescale 1ns / 1ps

module mhec_debounce (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [mhec_pkg::DATA_W-1:0]  i_med,
    input  mhec_pkg::t_cfg               i_cfg,
    output logic                         o_drowsy_next
);
    import mhec_pkg::*;

    logic [DATA_W-1:0] r_closed;
    logic [DATA_W-1:0] r_open;
    logic              r_drowsy;
    logic [DATA_W-1:0] n_closed;
    logic [DATA_W-1:0] n_open;
    logic              n_drowsy;

    // Hysteresis counters; the closed test wins when the thresholds overlap.
    always_comb begin
        n_closed = r_closed;
        n_open   = r_open;
        if (i_med < i_cfg.close_threshold) begin
            if (r_closed != COUNT_MAX) begin
                n_closed = r_closed + 16'd1;
            end
            n_open = '0;
        end else if (i_med > i_cfg.open_threshold) begin
            if (r_open != COUNT_MAX) begin
                n_open = r_open + 16'd1;
            end
            n_closed = '0;
        end
        n_drowsy = r_drowsy;
        if (n_closed > i_cfg.closed_limit) begin
            n_drowsy = 1'b1;
        end
        if (n_open > i_cfg.open_limit) begin
            n_drowsy = 1'b0;
        end
    end

    assign o_drowsy_next = n_drowsy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed <= '0;
            r_open   <= '0;
            r_drowsy <= 1'b0;
        end else if (i_load) begin
            r_closed <= n_closed;
            r_open   <= n_open;
            r_drowsy <= n_drowsy;
        end
    end

endmodule

// ===== hdl/median_hysteresis_eye_closure.sv =====
`timescale 1ns / 1ps
// A request is accepted, its sample inserted in the sorted chain in S_INS and its
// result loaded in S_OUT once the output is free, when a next request may enter.
// The chain deletes at the accept edge when full and inserts in the next cycle.
// Reset (synchronous, active low) empties the window, clears the counters and the
// drowsy flag, and loads the register defaults; the sample contents are not cleared.
module median_hysteresis_eye_closure #(
    parameter int unsigned WINDOW = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mhec_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mhec_pkg::DATA_W-1:0]       i_cfg_data,
    mhec_in_if.sink                           i_in,
    mhec_out_if.source                        o_out
);
    import mhec_pkg::*;

    localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CW = $clog2(WINDOW + 1);

    t_state                        r_state;
    t_state                        n_state;
    t_cfg                          r_cfg;
    logic [CW-1:0]                 r_fill;
    logic [DATA_W-1:0]             r_avg;
    logic                          r_out_valid;
    logic [DATA_W-1:0]             r_out_ratio;
    logic                          r_out_drowsy;
    logic                          full;
    logic                          accept;
    logic                          out_free;
    logic                          load_out;
    logic [DATA_W:0]               sum;
    logic [AW-1:0]                 med_idx;
    logic [DATA_W-1:0]             med;
    logic                          drowsy_next;
    t_chain_ctrl                   ctrl;
    logic [WINDOW-1:0][DATA_W-1:0] values;

    assign full     = (r_fill == CW'(WINDOW));
    assign out_free = !r_out_valid || o_out.ready;
    assign load_out = (r_state == S_OUT) && out_free;
    assign accept   = i_in.valid && i_in.ready;
    assign sum      = {1'b0, i_in.left_ratio} + {1'b0, i_in.right_ratio};
    assign med_idx  = AW'(r_fill >> 1);
    assign med      = values[med_idx];

    // Sequencer: accept, insert, then hand the result to the output register.
    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        ctrl       = '{del: 1'b0, ins: 1'b0, full: full};
        unique case (r_state)
            S_IDLE: begin
                // In S_IDLE no request is taken while reset is held.
                i_in.ready = i_rst_n;
            end
            S_INS: begin
                ctrl.ins = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                i_in.ready = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // The oldest sample leaves at the accept edge when the window is full.
        if (accept) begin
            ctrl.del = full;
            n_state  = S_INS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Average of the two ratios, held for the insert step.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_avg <= sum[DATA_W:1];
        end
    end

    // Number of samples held, counted up on each insert until the window is full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (ctrl.ins && !full) begin
            r_fill <= r_fill + CW'(1);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{close_threshold: RST_CLOSE_THRESHOLD,
                       open_threshold:  RST_OPEN_THRESHOLD,
                       closed_limit:    RST_CLOSED_LIMIT,
                       open_limit:      RST_OPEN_LIMIT};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLOSE_THRESHOLD: r_cfg.close_threshold <= i_cfg_data;
                CFG_OPEN_THRESHOLD:  r_cfg.open_threshold  <= i_cfg_data;
                CFG_CLOSED_LIMIT:    r_cfg.closed_limit    <= i_cfg_data;
                CFG_OPEN_LIMIT:      r_cfg.open_limit      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mhec_chain #(
        .WINDOW (WINDOW),
        .AW     (AW)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_new_value (r_avg),
        .o_values    (values)
    );

    mhec_debounce u_debounce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load_out),
        .i_med         (med),
        .i_cfg         (r_cfg),
        .o_drowsy_next (drowsy_next)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_ratio  <= med;
            r_out_drowsy <= drowsy_next;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.filtered_ratio = r_out_ratio;
    assign o_out.drowsy         = r_out_drowsy;

endmodule

// ===== test/tb_median_hysteresis_eye_closure.sv =====
`timescale 1ns / 1ps

module tb_median_hysteresis_eye_closure;
    import mhec_pkg::*;

    localparam int unsigned WIN         = 5;
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned PHASE_ITEMS = 200;
    localparam int unsigned NUM_PHASES  = 8;

    // Kind of eye state that a run of generated requests aims at.
    typedef enum int {
        EYE_CLOSED,
        EYE_OPEN,
        EYE_BETWEEN,
        EYE_NOISE
    } t_eye_mode;

    // One predicted result of the filter.
    typedef struct packed {
        logic [DATA_W-1:0] filtered_ratio;
        logic              drowsy;
    } t_eye_result;

    // Predicts the median filter and debounce and checks the results in order.
    class eye_closure_scoreboard;
        logic [DATA_W-1:0] close_thr;
        logic [DATA_W-1:0] open_thr;
        logic [DATA_W-1:0] drowsy_lim;
        logic [DATA_W-1:0] awake_lim;
        logic [DATA_W-1:0] samples [WIN];
        int unsigned       fill;
        int unsigned       slot;
        logic [DATA_W-1:0] closed_cnt;
        logic [DATA_W-1:0] open_cnt;
        logic              drowsy_q;
        t_eye_result       expected_q [$];
        int unsigned       errors;

        function new();
            close_thr  = RST_CLOSE_THRESHOLD;
            open_thr   = RST_OPEN_THRESHOLD;
            drowsy_lim = RST_CLOSED_LIMIT;
            awake_lim  = RST_OPEN_LIMIT;
            fill       = 0;
            slot       = 0;
            closed_cnt = '0;
            open_cnt   = '0;
            drowsy_q   = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                CFG_CLOSE_THRESHOLD: close_thr  = val;
                CFG_OPEN_THRESHOLD:  open_thr   = val;
                CFG_CLOSED_LIMIT:    drowsy_lim = val;
                CFG_OPEN_LIMIT:      awake_lim  = val;
                default: ;
            endcase
        endfunction

        // Pushes the averaged pair into the ring, takes the median and
        // updates the debounce counters and the drowsy flag.
        function void note_request(logic [DATA_W-1:0] left, logic [DATA_W-1:0] right);
            logic [DATA_W:0]   pair_sum;
            logic [DATA_W-1:0] ordered [WIN];
            logic [DATA_W-1:0] v;
            logic [DATA_W-1:0] med;
            int                j;
            t_eye_result       res;
            pair_sum = {1'b0, left} + {1'b0, right};
            samples[slot] = pair_sum[DATA_W:1];
            slot = (slot + 1 >= WIN) ? 0 : slot + 1;
            if (fill < WIN) fill++;

            // Insertion sort over the samples held so far.
            for (int i = 0; i < fill; i++) begin
                v = samples[i];
                j = i;
                while (j > 0 && ordered[j-1] > v) begin
                    ordered[j] = ordered[j-1];
                    j--;
                end
                ordered[j] = v;
            end
            med = ordered[fill / 2];

            // The closed test takes priority when the thresholds overlap.
            if (med < close_thr) begin
                if (closed_cnt != COUNT_MAX) closed_cnt++;
                open_cnt = '0;
            end else if (med > open_thr) begin
                if (open_cnt != COUNT_MAX) open_cnt++;
                closed_cnt = '0;
            end
            if (closed_cnt > drowsy_lim) drowsy_q = 1'b1;
            if (open_cnt > awake_lim) drowsy_q = 1'b0;

            res.filtered_ratio = med;
            res.drowsy         = drowsy_q;
            expected_q = {expected_q, res};
        endfunction

        function void check_result(logic [DATA_W-1:0] ratio, logic drowsy);
            t_eye_result exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, filtered_ratio %h drowsy %b",
                         $time, ratio, drowsy);
                errors++;
                return;
            end
            exp_res = expected_q[0];
            expected_q.delete(0);
            if (exp_res.filtered_ratio !== ratio) begin
                $display("%0t: filtered_ratio mismatch, expected %h actual %h",
                         $time, exp_res.filtered_ratio, ratio);
                errors++;
            end
            if (exp_res.drowsy !== drowsy) begin
                $display("%0t: drowsy mismatch, expected %b actual %b",
                         $time, exp_res.drowsy, drowsy);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;

    mhec_in_if  req_if ();
    mhec_out_if res_if ();

    eye_closure_scoreboard sb = new();
    bit calm_mode;

    median_hysteresis_eye_closure #(
        .WINDOW (WIN)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (req_if),
        .o_out       (res_if)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then long; always none in calm mode.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm_mode) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Picks one eye ratio that tends toward the requested eye state.
    function automatic logic [DATA_W-1:0] pick_ratio(t_eye_mode mode);
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        lo = (sb.close_thr < sb.open_thr) ? sb.close_thr : sb.open_thr;
        hi = (sb.close_thr < sb.open_thr) ? sb.open_thr : sb.close_thr;
        case (mode)
            EYE_CLOSED:  return DATA_W'($urandom_range(0, sb.close_thr));
            EYE_OPEN:    return DATA_W'($urandom_range(sb.open_thr, COUNT_MAX));
            EYE_BETWEEN: return DATA_W'($urandom_range(lo, hi));
            default:     return DATA_W'($urandom);
        endcase
    endfunction

    // Accepted requests feed the predictor; accepted results are checked.
    always @(posedge i_clk) begin
        if (req_if.valid && req_if.ready) begin
            sb.note_request(req_if.left_ratio, req_if.right_ratio);
        end
        if (res_if.valid && res_if.ready) begin
            sb.check_result(res_if.filtered_ratio, res_if.drowsy);
        end
    end

    // Result side back-pressure: bursts of ready with random stalls.
    initial begin : result_sink
        int unsigned n;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            n = gap_len();
            if (n > 0) begin
                res_if.ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb_median_hysteresis_eye_closure NOT OK");
        $finish;
    end

    // Presents one request, waits for its acceptance, then idles for gap cycles.
    task automatic send_request(logic [DATA_W-1:0] left, logic [DATA_W-1:0] right,
                                int unsigned gap);
        req_if.valid       <= 1'b1;
        req_if.left_ratio  <= left;
        req_if.right_ratio <= right;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every expected result has been taken.
    task automatic drain(int unsigned settle);
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // Writes the full register set while the block is idle.
    task automatic apply_settings(logic [DATA_W-1:0] close_v, logic [DATA_W-1:0] open_v,
                                  logic [DATA_W-1:0] drowsy_v, logic [DATA_W-1:0] awake_v);
        drain(4);
        write_reg(CFG_CLOSE_THRESHOLD, close_v);
        write_reg(CFG_OPEN_THRESHOLD, open_v);
        write_reg(CFG_CLOSED_LIMIT, drowsy_v);
        write_reg(CFG_OPEN_LIMIT, awake_v);
        i_cfg_we <= 1'b0;
    endtask

    // Field extremes, threshold edges, overlapping thresholds and zero confirms.
    task automatic run_directed();
        logic [2*DATA_W-1:0] edge_pairs [12];
        edge_pairs = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_FFFF,
            32'h0001_0000, 32'hAAAA_5555, 32'h5555_AAAA, 32'h0CCD_0CCD,
            32'h0CCC_0CCC, 32'h0CCC_0CCE, 32'h1000_1000, 32'h1001_1001
        };
        foreach (edge_pairs[k]) begin
            send_request(edge_pairs[k][2*DATA_W-1:DATA_W], edge_pairs[k][DATA_W-1:0],
                         gap_len());
        end

        // Close above open: the in-between value must count as closed.
        apply_settings(16'h2000, 16'h1000, 16'h0000, 16'h0000);
        repeat (3) send_request(16'h1800, 16'h1800, gap_len());
        repeat (3) send_request(16'hFFFF, 16'hFFFF, gap_len());
        repeat (3) send_request(16'h0000, 16'h0000, gap_len());
    endtask

    // Register set for each random phase, extremes included.
    task automatic configure_phase(int unsigned p);
        logic [DATA_W-1:0] c;
        logic [DATA_W-1:0] o;
        c = DATA_W'($urandom_range(1000, 8000));
        o = c + DATA_W'($urandom_range(0, 4000));
        calm_mode = (p == 6);
        case (p)
            0: apply_settings(RST_CLOSE_THRESHOLD, RST_OPEN_THRESHOLD,
                              RST_CLOSED_LIMIT, RST_OPEN_LIMIT);
            2: apply_settings(16'h0000, 16'h0000, DATA_W'($urandom_range(0, 20)),
                              DATA_W'($urandom_range(0, 20)));
            3: apply_settings(16'hFFFF, 16'hFFFF, DATA_W'($urandom_range(0, 20)),
                              DATA_W'($urandom_range(0, 20)));
            4: apply_settings(o, c, DATA_W'($urandom_range(0, 20)),
                              DATA_W'($urandom_range(0, 20)));
            5: apply_settings(c, o, COUNT_MAX, COUNT_MAX);
            7: apply_settings(c, o, 16'h0000, 16'h0000);
            default: apply_settings(c, o, DATA_W'($urandom_range(0, 20)),
                                    DATA_W'($urandom_range(0, 20)));
        endcase
    endtask

    // Runs of closed, open or in-between eyes with random content, plus noise.
    task automatic run_random_phase(int unsigned n_items);
        int unsigned sent;
        int unsigned run_len;
        int unsigned r;
        t_eye_mode   mode;
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 9);
            if (r < 4) mode = EYE_CLOSED;
            else if (r < 8) mode = EYE_OPEN;
            else if (r < 9) mode = EYE_BETWEEN;
            else mode = EYE_NOISE;
            run_len = $urandom_range(1, 25);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                left  = pick_ratio(mode);
                right = ($urandom_range(0, 7) == 0) ? pick_ratio(EYE_NOISE) : pick_ratio(mode);
                send_request(left, right, gap_len());
                sent++;
                // Halfway through, hold off until the block has emptied.
                if (sent == n_items / 2) drain(0);
            end
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= CFG_CLOSE_THRESHOLD;
        i_cfg_data         <= '0;
        req_if.valid       <= 1'b0;
        req_if.left_ratio  <= '0;
        req_if.right_ratio <= '0;
        calm_mode = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            configure_phase(p);
            run_random_phase(PHASE_ITEMS);
        end

        drain(8);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_median_hysteresis_eye_closure OK");
        end else begin
            $display("tb_median_hysteresis_eye_closure NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mhec_pkg.sv
hdl/mhec_if.sv
hdl/mhec_cell.sv
hdl/mhec_chain.sv
hdl/mhec_debounce.sv
hdl/median_hysteresis_eye_closure.sv
test/tb_median_hysteresis_eye_closure.sv
